// ----- hw/rtl/fbs_pkg.sv -----
// ----------------------------------------------------------------------------
// fbs_pkg
// Types and constants shared by the function boundary scanner.
// ----------------------------------------------------------------------------
package fbs_pkg;

	typedef enum logic [2:0] {
		ST_SCAN    = 3'd0,
		ST_END     = 3'd1,
		ST_LIMIT   = 3'd2,
		ST_INVALID = 3'd3,
		ST_RANGE   = 3'd4,
		ST_IDLE    = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		REG_BASE_ADDR  = 1'b0,
		REG_SIZE_LIMIT = 1'b1
	} reg_index_t;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned SIZE_W  = 18;
	localparam int unsigned COUNT_W = 16;

	localparam logic [31:0] OP_BLR   = 32'h4E80_0020;
	localparam logic [31:0] OP_RFI   = 32'h4C00_0064;
	localparam logic [31:0] OP_BLRL  = 32'h4E80_0021;
	localparam logic [31:0] OP_BCTR  = 32'h4E80_0420;
	localparam logic [31:0] OP_BCTRL = 32'h4E80_0421;

	localparam logic [5:0] OPC_BC = 6'd16;
	localparam logic [5:0] OPC_B  = 6'd18;

endpackage

// ----- hw/rtl/function_boundary_scanner.sv -----
// ----------------------------------------------------------------------------
// function_boundary_scanner
// Walks instruction words of a function, reports direct calls, and flags
// the end of the function, size limit, invalid word or range exit.
// ----------------------------------------------------------------------------
// Each result is registered when its word is accepted.
// Throughput: one word per cycle unless stalled; the scan state updates
// at each accepted word and the next word uses it in the following cycle.
// Input stall is raised only while a finished result waits on output stall.
// Reset: scan stopped, count and farthest target zero, leaf mark set,
// configuration registers zero, no result pending.
module function_boundary_scanner #(
	parameter int unsigned SCAN_LIMIT_WORDS = 32768
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  fbs_pkg::reg_index_t       wr_index,
	input  logic [31:0]               wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      first,
	input  logic [31:0]               instr_word,
	input  logic                      in_iram,
	input  logic                      valid_inst,
	output logic                      out_valid,
	input  logic                      out_stall,
	output fbs_pkg::status_t          status,
	output logic [17:0]               size_bytes,
	output logic                      is_leaf,
	output logic                      is_straight,
	output logic                      indirect_call,
	output logic                      call_found,
	output logic [31:0]               call_target,
	output logic [31:0]               call_site
);
	import fbs_pkg::*;

	logic [ADDR_W-1:0]  base_addr_q;
	logic [SIZE_W-1:0]  size_limit_q;
	logic               scan_q;
	logic [COUNT_W-1:0] wc_q;
	logic [ADDR_W-1:0]  far_q;
	logic               sib_q;
	logic               leaf_q;
	logic               ind_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [SIZE_W-1:0]  size_q;
	logic               leaf_out_q;
	logic               straight_q;
	logic               ind_out_q;
	logic               call_q;
	logic [ADDR_W-1:0]  tgt_q;
	logic [ADDR_W-1:0]  site_q;

	logic               in_acc;
	logic               scan_d;
	logic [COUNT_W-1:0] wc_d;
	logic [ADDR_W-1:0]  far_d;
	logic               sib_d;
	logic               leaf_d;
	logic               ind_d;
	status_t            st_d;
	logic               call_d;
	logic [ADDR_W-1:0]  tgt_d;
	logic [ADDR_W-1:0]  site_d;

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	always_comb begin
		logic               e_scan;
		logic [COUNT_W-1:0] e_wc;
		logic [ADDR_W-1:0]  e_far;
		logic [COUNT_W-1:0] cnt;
		logic [ADDR_W-1:0]  addr;
		logic [5:0]         opcd;
		logic               is_br;
		logic [ADDR_W-1:0]  rel;
		logic [ADDR_W-1:0]  target;
		logic [ADDR_W:0]    range_end;
		logic               ext;

		e_scan    = first | scan_q;
		e_wc      = first ? '0 : wc_q;
		e_far     = first ? base_addr_q : far_q;
		cnt       = e_wc + COUNT_W'(1);
		addr      = base_addr_q + {{(ADDR_W-COUNT_W-2){1'b0}}, e_wc, 2'b00};
		opcd      = instr_word[31:26];
		is_br     = (opcd == OPC_BC) || (opcd == OPC_B);
		rel       = (opcd == OPC_BC)
			? {{16{instr_word[15]}}, instr_word[15:2], 2'b00}
			: {{6{instr_word[25]}}, instr_word[25:2], 2'b00};
		target    = instr_word[1] ? rel : rel + addr;
		range_end = {1'b0, base_addr_q} + {{(ADDR_W+1-SIZE_W){1'b0}}, size_limit_q};
		ext       = (target < base_addr_q) ||
			((size_limit_q != '0) && ({1'b0, target} >= range_end));

		scan_d = e_scan;
		wc_d   = e_wc;
		far_d  = e_far;
		sib_d  = first ? 1'b0 : sib_q;
		leaf_d = first ? 1'b1 : leaf_q;
		ind_d  = first ? 1'b0 : ind_q;
		st_d   = ST_SCAN;
		call_d = 1'b0;
		tgt_d  = '0;
		site_d = '0;

		priority if (!e_scan) begin
			st_d = ST_IDLE;
		end else if ((cnt >= COUNT_W'(SCAN_LIMIT_WORDS)) || !in_iram) begin
			wc_d   = cnt;
			scan_d = 1'b0;
			st_d   = ST_RANGE;
		end else if ((size_limit_q != '0) && ({cnt, 2'b00} > size_limit_q)) begin
			scan_d = 1'b0;
			st_d   = ST_LIMIT;
		end else if (!valid_inst) begin
			wc_d   = cnt;
			scan_d = 1'b0;
			st_d   = ST_INVALID;
		end else begin
			wc_d = cnt;
			priority if ((instr_word == OP_BLR) || (instr_word == OP_RFI)) begin
				if (e_far <= addr) begin
					scan_d = 1'b0;
					st_d   = ST_END;
				end
			end else if ((instr_word == OP_BLRL) || (instr_word == OP_BCTR) ||
					(instr_word == OP_BCTRL)) begin
				leaf_d = 1'b0;
				ind_d  = 1'b1;
			end else if (is_br) begin
				if (instr_word[0] || ext) begin
					leaf_d = 1'b0;
					call_d = 1'b1;
					tgt_d  = target;
					site_d = addr;
				end else if (opcd == OPC_BC) begin
					if (target > e_far) begin
						far_d = target;
					end
					sib_d = 1'b1;
				end
			end else begin
				st_d = ST_SCAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q  <= '0;
			size_limit_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BASE_ADDR:  base_addr_q  <= wr_data;
				REG_SIZE_LIMIT: size_limit_q <= wr_data[SIZE_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= 1'b0;
			wc_q        <= '0;
			far_q       <= '0;
			sib_q       <= 1'b0;
			leaf_q      <= 1'b1;
			ind_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				scan_q <= scan_d;
				wc_q   <= wc_d;
				far_q  <= far_d;
				sib_q  <= sib_d;
				leaf_q <= leaf_d;
				ind_q  <= ind_d;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q   <= st_d;
			size_q     <= {wc_d, 2'b00};
			leaf_out_q <= leaf_d;
			straight_q <= ~sib_d;
			ind_out_q  <= ind_d;
			call_q     <= call_d;
			tgt_q      <= tgt_d;
			site_q     <= site_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign size_bytes    = size_q;
	assign is_leaf       = leaf_out_q;
	assign is_straight   = straight_q;
	assign indirect_call = ind_out_q;
	assign call_found    = call_q;
	assign call_target   = tgt_q;
	assign call_site     = site_q;

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !first && !scan_q |=> out_valid && (status == ST_IDLE))
		else $error("idle transaction did not report idle");

	a_scan_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> scan_q == (status == ST_SCAN))
		else $error("scan state disagrees with reported status");

	a_call_only_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && call_found |-> (status == ST_SCAN) && !is_leaf)
		else $error("call reported outside a running scan or with leaf set");

	a_indirect_not_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !(indirect_call && is_leaf))
		else $error("indirect call seen but leaf still set");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams instruction words through the function boundary scanner under
// random input gaps and output stalls. A scoreboard tracks the scan state,
// predicts the report for every accepted word and checks each report in order.
// ----------------------------------------------------------------------------
module testbench;
	import fbs_pkg::*;

	localparam int unsigned SCAN_LIMIT = 100;
	localparam int unsigned ITEMS      = 1100;
	localparam int unsigned PHASES     = 6;

	typedef struct packed {
		status_t     status;
		logic [17:0] size;
		logic        leaf;
		logic        straight;
		logic        indirect;
		logic        call;
		logic [31:0] target;
		logic [31:0] site;
	} scan_report_t;

	class scan_scoreboard;
		logic [31:0]  func_base;
		logic [17:0]  size_limit;
		logic         scanning;
		logic [15:0]  word_count;
		logic [31:0]  farthest;
		logic         saw_branch;
		logic         leaf;
		logic         indirect;
		scan_report_t scan_reports[$];
		int           mismatches;
		int           words_scanned;

		function new();
			func_base     = '0;
			size_limit    = '0;
			scanning      = 1'b0;
			word_count    = '0;
			farthest      = '0;
			saw_branch    = 1'b0;
			leaf          = 1'b1;
			indirect      = 1'b0;
			mismatches    = 0;
			words_scanned = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [31:0] data);
			if (idx == REG_BASE_ADDR) begin
				func_base = data;
			end else begin
				size_limit = data[17:0];
			end
		endfunction

		function int outstanding();
			return scan_reports.size();
		endfunction

		function void emit(status_t st, logic call, logic [31:0] tgt, logic [31:0] site);
			scan_report_t r;
			r.status   = st;
			r.size     = {word_count, 2'b00};
			r.leaf     = leaf;
			r.straight = !saw_branch;
			r.indirect = indirect;
			r.call     = call;
			r.target   = call ? tgt : 32'd0;
			r.site     = call ? site : 32'd0;
			scan_reports = {scan_reports, r};
			if (st != ST_IDLE) begin
				words_scanned++;
			end
		endfunction

		function void scan_word(logic f, logic [31:0] w, logic iram, logic vi);
			logic [15:0] count;
			logic [31:0] addr;
			logic [31:0] tgt;
			logic [5:0]  opcd;
			logic        branch;
			logic        off_range;
			if (f) begin
				scanning   = 1'b1;
				word_count = '0;
				farthest   = func_base;
				saw_branch = 1'b0;
				leaf       = 1'b1;
				indirect   = 1'b0;
			end
			if (!scanning) begin
				emit(ST_IDLE, 1'b0, '0, '0);
				return;
			end
			count = word_count + 16'd1;
			addr  = func_base + {14'd0, word_count, 2'b00};
			if (32'(count) >= SCAN_LIMIT || !iram) begin
				word_count = count;
				scanning   = 1'b0;
				emit(ST_RANGE, 1'b0, '0, '0);
				return;
			end
			if (size_limit != 0 && {count, 2'b00} > size_limit) begin
				scanning = 1'b0;
				emit(ST_LIMIT, 1'b0, '0, '0);
				return;
			end
			if (!vi) begin
				word_count = count;
				scanning   = 1'b0;
				emit(ST_INVALID, 1'b0, '0, '0);
				return;
			end
			word_count = count;
			if (w == OP_BLR || w == OP_RFI) begin
				if (farthest > addr) begin
					emit(ST_SCAN, 1'b0, '0, '0);
				end else begin
					scanning = 1'b0;
					emit(ST_END, 1'b0, '0, '0);
				end
				return;
			end
			if (w == OP_BLRL || w == OP_BCTR || w == OP_BCTRL) begin
				leaf     = 1'b0;
				indirect = 1'b1;
				emit(ST_SCAN, 1'b0, '0, '0);
				return;
			end
			opcd   = w[31:26];
			branch = 1'b1;
			tgt    = '0;
			if (opcd == OPC_BC) begin
				tgt = {{16{w[15]}}, w[15:2], 2'b00};
			end else if (opcd == OPC_B) begin
				tgt = {{6{w[25]}}, w[25:2], 2'b00};
			end else begin
				branch = 1'b0;
			end
			if (!branch) begin
				emit(ST_SCAN, 1'b0, '0, '0);
				return;
			end
			if (!w[1]) begin
				tgt = tgt + addr;
			end
			off_range = (tgt < func_base) || (size_limit != 0 &&
				{1'b0, tgt} >= {1'b0, func_base} + 33'(size_limit));
			if (w[0] || off_range) begin
				leaf = 1'b0;
				emit(ST_SCAN, 1'b1, tgt, addr);
				return;
			end
			if (opcd == OPC_BC) begin
				if (tgt > farthest) begin
					farthest = tgt;
				end
				saw_branch = 1'b1;
			end
			emit(ST_SCAN, 1'b0, '0, '0);
		endfunction

		function string describe(scan_report_t r);
			return $sformatf(
				"st=%0d size=%0d leaf=%b straight=%b ind=%b call=%b tgt=%h site=%h",
				r.status, r.size, r.leaf, r.straight, r.indirect, r.call, r.target, r.site);
		endfunction

		function void check_report(scan_report_t got);
			scan_report_t exp;
			if (scan_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%t: unexpected report: %s", $realtime, describe(got));
				end
				return;
			end
			exp = scan_reports.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%t: report mismatch\n  exp %s\n  got %s", $realtime,
						describe(exp), describe(got));
				end
			end
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        wr_en       = 1'b0;
	reg_index_t  wr_index    = REG_BASE_ADDR;
	logic [31:0] wr_data     = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic        first       = 1'b0;
	logic [31:0] instr_word  = '0;
	logic        in_iram     = 1'b0;
	logic        valid_inst  = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	status_t     status;
	logic [17:0] size_bytes;
	logic        is_leaf;
	logic        is_straight;
	logic        indirect_call;
	logic        call_found;
	logic [31:0] call_target;
	logic [31:0] call_site;

	logic        no_idle   = 1'b0;
	int          hold_req  = 0;
	int          hold_done = 0;

	scan_scoreboard sb;

	function_boundary_scanner #(
		.SCAN_LIMIT_WORDS(SCAN_LIMIT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.first         (first),
		.instr_word    (instr_word),
		.in_iram       (in_iram),
		.valid_inst    (valid_inst),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.size_bytes    (size_bytes),
		.is_leaf       (is_leaf),
		.is_straight   (is_straight),
		.indirect_call (indirect_call),
		.call_found    (call_found),
		.call_target   (call_target),
		.call_site     (call_site)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		scan_report_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.status   = status;
				got.size     = size_bytes;
				got.leaf     = is_leaf;
				got.straight = is_straight;
				got.indirect = indirect_call;
				got.call     = call_found;
				got.target   = call_target;
				got.site     = call_site;
				sb.check_report(got);
			end
			if (in_valid && !in_stall) begin
				sb.scan_word(first, instr_word, in_iram, valid_inst);
			end
		end
	end

	// receiver: random stalls, or one long hold-off on request
	always begin
		@(negedge clk);
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			out_stall = 1'b1;
			repeat (60) @(negedge clk);
			out_stall = 1'b0;
		end else begin
			out_stall = !no_idle && ($urandom_range(99) < 17);
		end
	end

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic send_word(logic f, logic [31:0] w, logic iram, logic vi);
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 17) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		first      = f;
		instr_word = w;
		in_iram    = iram;
		valid_inst = vi;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] make_word(int idx, bit allow_end);
		int          pick;
		int          back;
		logic [31:0] w;
		pick = $urandom_range(99);
		w    = $urandom;
		if (pick < 15) begin
			w = {OPC_BC, 10'($urandom), 14'($urandom_range(1, 12)), 2'b00};
		end else if (pick < 20) begin
			back = $urandom_range(0, idx);
			w    = {OPC_BC, 10'($urandom), 14'(-back), 2'b00};
		end else if (pick < 28) begin
			w = {OPC_BC, 24'($urandom), 2'($urandom)};
		end else if (pick < 38) begin
			w = {OPC_B, 24'($urandom), 1'($urandom_range(0, 4) == 0), 1'b1};
		end else if (pick < 43) begin
			w = {OPC_B, 24'($urandom), 1'($urandom), 1'b0};
		end else if (pick < 49) begin
			case ($urandom_range(2))
				0: w = OP_BLRL;
				1: w = OP_BCTR;
				default: w = OP_BCTRL;
			endcase
		end else if (pick < 56 && allow_end) begin
			w = $urandom_range(1) ? OP_BLR : OP_RFI;
		end
		return w;
	endfunction

	// mostly well-formed functions, some running to the word limit, some noise
	task automatic run_scan();
		int          len;
		bit          noise;
		bit          long_scan;
		logic        f;
		logic        iram;
		logic        vi;
		logic [31:0] w;
		noise     = ($urandom_range(9) == 0);
		long_scan = !noise && ($urandom_range(9) == 0);
		len       = long_scan ? SCAN_LIMIT + 3 : $urandom_range(1, 30);
		for (int i = 0; i < len; i++) begin
			if (noise) begin
				f    = (i == 0) || $urandom_range(1);
				w    = $urandom_range(1) ? 32'($urandom) : make_word(i, 1'b1);
				iram = 1'($urandom_range(1));
				vi   = 1'($urandom_range(1));
			end else begin
				f    = (i == 0) || ($urandom_range(99) < 2);
				w    = make_word(i, !long_scan);
				iram = long_scan || ($urandom_range(99) >= 2);
				vi   = long_scan || ($urandom_range(99) >= 2);
			end
			send_word(f, w, iram, vi);
		end
		if (!noise && !long_scan && $urandom_range(9) < 7) begin
			send_word(1'b0, $urandom_range(1) ? OP_BLR : OP_RFI, 1'b1, 1'b1);
		end
	endtask

	initial begin
		logic [31:0] phase_start[PHASES];
		logic [17:0] phase_max[PHASES];
		int          goal;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_BASE_ADDR, 32'h0000_0100);
		write_reg(REG_SIZE_LIMIT, 32'd32);
		send_word(1'b0, 32'h0000_0000, 1'b1, 1'b1);
		send_word(1'b1, 32'h0000_0000, 1'b1, 1'b1);
		send_word(1'b0, {OPC_BC, 10'h182, 14'd4, 2'b00}, 1'b1, 1'b1);
		send_word(1'b0, OP_BLR, 1'b1, 1'b1);
		send_word(1'b0, {OPC_B, 24'd16, 2'b01}, 1'b1, 1'b1);
		send_word(1'b0, {OPC_B, 24'hFF_FFF8, 2'b00}, 1'b1, 1'b1);
		send_word(1'b0, OP_BLRL, 1'b1, 1'b1);
		send_word(1'b0, OP_RFI, 1'b1, 1'b1);
		send_word(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_word(1'b1, OP_BCTR, 1'b1, 1'b1);
		send_word(1'b0, OP_BCTRL, 1'b1, 1'b1);
		send_word(1'b0, {OPC_BC, 10'h000, 14'd10, 2'b10}, 1'b1, 1'b1);
		send_word(1'b0, {OPC_B, 24'h40, 2'b10}, 1'b1, 1'b1);
		send_word(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_word(1'b1, 32'h0000_0000, 1'b0, 1'b1);
		send_word(1'b1, 32'h0000_0000, 1'b1, 1'b0);
		send_word(1'b1, 32'h0000_0000, 1'b1, 1'b1);
		repeat (8) send_word(1'b0, 32'h6000_0000, 1'b1, 1'b1);
		wait_drained();
		repeat (3) @(negedge clk);

		phase_start[0] = 32'h0000_0000;
		phase_max[0]   = 18'd0;
		phase_start[1] = 32'hFFFF_FF00;
		phase_max[1]   = 18'd0;
		phase_start[2] = $urandom & 32'hFFFF_FFFC;
		phase_max[2]   = 18'(4 * $urandom_range(1, 40));
		phase_start[3] = 32'h0000_1002;
		phase_max[3]   = 18'd131072;
		phase_start[4] = 32'hFFFF_FFFF;
		phase_max[4]   = 18'd131072;
		phase_start[5] = $urandom & 32'hFFFF_FFFC;
		phase_max[5]   = 18'(4 * $urandom_range(20, 90));

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_BASE_ADDR, phase_start[p]);
			write_reg(REG_SIZE_LIMIT, 32'(phase_max[p]));
			no_idle = (p == 2);
			if (p == 1) begin
				hold_req++;
			end
			if (p == 3) begin
				repeat (5) run_scan();
				wait_drained();
			end
			goal = ITEMS * (p + 1) / PHASES;
			while (sb.words_scanned < goal) run_scan();
			wait_drained();
			repeat (3) @(negedge clk);
		end

		repeat (5) @(negedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
